@@ design/assert_macros.svh @@
// assertion macros shared by the search unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ORS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("search unit check failed");

// next-cycle implication, checked outside reset
`define ORS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("search unit check failed");

`endif

@@ design/ors_pkg.sv @@
// types and constants of the search-rom decision core
package ors_pkg;

    localparam int unsigned ID_BYTES   = 8;
    localparam int unsigned TOTAL_BITS = ID_BYTES * 8;
    localparam int unsigned ROM_W      = 64;
    localparam int unsigned IDX_W      = $clog2(ROM_W);
    localparam int unsigned POS_W      = 7;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [ROM_W-1:0] t_rom;
    typedef logic [1:0]       t_kind;
    typedef logic [2:0]       t_status;

    localparam t_pos TOTAL_POS    = t_pos'(TOTAL_BITS);
    localparam t_pos FAMILY_LIMIT = t_pos'(9);

    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_BEGIN = 2'd1;
    localparam t_kind KIND_PAIR  = 2'd2;

    localparam t_status ST_SEND    = 3'd0;
    localparam t_status ST_FOUND   = 3'd1;
    localparam t_status ST_FAIL    = 3'd2;
    localparam t_status ST_STARTED = 3'd3;
    localparam t_status ST_IGNORED = 3'd4;

    typedef struct packed {
        t_kind kind;
        logic  presence;
        logic  id_bit;
        logic  complement_bit;
    } t_item;

    typedef struct packed {
        t_status status;
        logic    direction;
        t_rom    rom_id;
        t_pos    family_discrepancy;
        logic    last_device;
    } t_result;

    typedef struct packed {
        logic advance;
        logic fire;
    } t_pipe_ctl;

endpackage

@@ design/ors_in_stage.sv @@
// input request register with stall back to the sender
module ors_in_stage
    import ors_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_item     i_item,
    input  t_pipe_ctl i_ctl,
    output logic      o_item_valid,
    output t_item     o_item
);

`include "assert_macros.svh"

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load         = !r_valid || i_ctl.advance;
    assign o_stall      = !load;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    // an empty register never holds off the sender
    `ORS_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !r_valid, !o_stall)
    // a held request is still there next cycle
    `ORS_ASSERT_NEXT(a_hold_request, i_clk, i_rst_n, r_valid && !i_ctl.advance, r_valid)

endmodule

@@ design/ors_decide.sv @@
// search state registers and the per-request direction decision
module ors_decide
    import ors_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_item,
    input  t_pipe_ctl i_ctl,
    output t_result   o_result
);

`include "assert_macros.svh"

    t_rom  r_rom, n_rom;
    t_pos  r_last_disc, n_last_disc;
    t_pos  r_fam_disc, n_fam_disc;
    logic  r_last_dev, n_last_dev;
    t_pos  r_bit_pos, n_bit_pos;
    t_pos  r_newest_zero, n_newest_zero;
    logic  r_pass, n_pass;

    t_pos       pos;
    logic [IDX_W-1:0] idx;
    logic       dir;
    t_status    status;

    assign pos = r_bit_pos + t_pos'(1);
    assign idx = r_bit_pos[IDX_W-1:0];

    always_comb begin
        n_rom         = r_rom;
        n_last_disc   = r_last_disc;
        n_fam_disc    = r_fam_disc;
        n_last_dev    = r_last_dev;
        n_bit_pos     = r_bit_pos;
        n_newest_zero = r_newest_zero;
        n_pass        = r_pass;
        dir           = 1'b0;
        status        = ST_IGNORED;
        case (i_item.kind)
            KIND_CLEAR: begin
                n_rom         = '0;
                n_last_disc   = '0;
                n_fam_disc    = '0;
                n_last_dev    = 1'b0;
                n_bit_pos     = '0;
                n_newest_zero = '0;
                n_pass        = 1'b0;
                status        = ST_STARTED;
            end
            KIND_BEGIN: begin
                n_bit_pos     = '0;
                n_newest_zero = '0;
                if (r_last_dev || !i_item.presence) begin
                    n_pass      = 1'b0;
                    n_last_disc = '0;
                    n_fam_disc  = '0;
                    n_last_dev  = 1'b0;
                    status      = ST_FAIL;
                end else begin
                    n_pass = 1'b1;
                    status = ST_STARTED;
                end
            end
            KIND_PAIR: begin
                if (r_pass) begin
                    if (i_item.id_bit && i_item.complement_bit) begin
                        // no device answered this position
                        n_last_disc = '0;
                        n_fam_disc  = '0;
                        n_last_dev  = 1'b0;
                        n_pass      = 1'b0;
                        status      = ST_FAIL;
                    end else begin
                        if (i_item.id_bit != i_item.complement_bit) begin
                            dir = i_item.id_bit;
                        end else begin
                            // discrepancy: follow last pass, take 1 at the marker
                            if (pos < r_last_disc) begin
                                dir = r_rom[idx];
                            end else begin
                                dir = (pos == r_last_disc);
                            end
                            if (!dir) begin
                                n_newest_zero = pos;
                                if (pos < FAMILY_LIMIT) begin
                                    n_fam_disc = pos;
                                end
                            end
                        end
                        n_rom[idx] = dir;
                        n_bit_pos  = pos;
                        status     = ST_SEND;
                        if (pos >= TOTAL_POS) begin
                            n_pass      = 1'b0;
                            n_last_disc = n_newest_zero;
                            if (n_newest_zero == '0) begin
                                n_last_dev = 1'b1;
                            end
                            if (n_rom[7:0] == 8'd0) begin
                                n_last_disc = '0;
                                n_fam_disc  = '0;
                                n_last_dev  = 1'b0;
                                status      = ST_FAIL;
                            end else begin
                                status = ST_FOUND;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom         <= '0;
            r_last_disc   <= '0;
            r_fam_disc    <= '0;
            r_last_dev    <= 1'b0;
            r_bit_pos     <= '0;
            r_newest_zero <= '0;
            r_pass        <= 1'b0;
        end else if (i_ctl.fire) begin
            r_rom         <= n_rom;
            r_last_disc   <= n_last_disc;
            r_fam_disc    <= n_fam_disc;
            r_last_dev    <= n_last_dev;
            r_bit_pos     <= n_bit_pos;
            r_newest_zero <= n_newest_zero;
            r_pass        <= n_pass;
        end
    end

    assign o_result.status             = status;
    assign o_result.direction          = dir;
    assign o_result.rom_id             = n_rom;
    assign o_result.family_discrepancy = n_fam_disc;
    assign o_result.last_device        = n_last_dev;

    // an open pass never runs past the last id bit
    `ORS_ASSERT_NOW(a_pos_in_range, i_clk, i_rst_n, r_pass, r_bit_pos < TOTAL_POS)
    // the last device leaves no discrepancy behind
    `ORS_ASSERT_NOW(a_last_dev_no_disc, i_clk, i_rst_n, r_last_dev, r_last_disc == '0)
    // family marker stays inside the family byte
    `ORS_ASSERT_NOW(a_family_range, i_clk, i_rst_n, 1'b1, r_fam_disc < FAMILY_LIMIT)

endmodule

@@ design/ors_out_stage.sv @@
// result register and pipeline advance control
module ors_out_stage
    import ors_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  t_result   i_result,
    output t_pipe_ctl o_ctl,
    output logic      o_valid,
    input  logic      i_stall,
    output t_result   o_result
);

`include "assert_macros.svh"

    logic    r_valid;
    t_result r_result;

    assign o_ctl.advance = !r_valid || !i_stall;
    assign o_ctl.fire    = i_item_valid && o_ctl.advance;
    assign o_valid       = r_valid;
    assign o_result      = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ctl.advance) begin
            r_valid <= i_item_valid;
        end
        if (o_ctl.fire) begin
            r_result <= i_result;
        end
    end

    // a request only fires into a free or draining result register
    `ORS_ASSERT_NOW(a_fire_room, i_clk, i_rst_n, o_ctl.fire, !(r_valid && i_stall))

endmodule

@@ design/onewire_rom_search_unit.sv @@
// top level of the one-wire search-rom decision core
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_kind i_presence i_id_bit i_complement_bit
//   result    out        o_valid / i_stall  o_status o_direction o_rom_id
//                                           o_family_discrepancy o_last_device
//
// one request per cycle while the result side does not stall; a result is presented once its
// request has passed the input register, the decision logic and the result register
// synchronous active-low reset clears the search state and empties both registers
// a stalled result holds both registers; the request side stalls once the input
// register is also full, so with a full pipe each stall cycle costs one request slot
module onewire_rom_search_unit
    import ors_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic       i_presence,
    input  logic       i_id_bit,
    input  logic       i_complement_bit,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic       o_direction,
    output logic [63:0] o_rom_id,
    output logic [6:0] o_family_discrepancy,
    output logic       o_last_device
);

    t_item     in_item;
    t_item     held_item;
    logic      held_valid;
    t_pipe_ctl ctl;
    t_result   decided;
    t_result   result;

    assign in_item.kind           = i_kind;
    assign in_item.presence       = i_presence;
    assign in_item.id_bit         = i_id_bit;
    assign in_item.complement_bit = i_complement_bit;

    ors_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (in_item),
        .i_ctl        (ctl),
        .o_item_valid (held_valid),
        .o_item       (held_item)
    );

    ors_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_ctl    (ctl),
        .o_result (decided)
    );

    ors_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_result     (decided),
        .o_ctl        (ctl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (result)
    );

    assign o_status             = result.status;
    assign o_direction          = result.direction;
    assign o_rom_id             = result.rom_id;
    assign o_family_discrepancy = result.family_discrepancy;
    assign o_last_device        = result.last_device;

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the search-rom decision core: simulated device populations and noise
module tb_top
    import ors_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 475;
    localparam int MAX_DEVICES    = 8;
    localparam t_kind KIND_SPARE  = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // predicts each search step and holds the results still owed by the block
    class search_scoreboard;
        t_rom    rom;
        t_pos    last_disc;
        t_pos    fam_disc;
        t_pos    bit_pos;
        t_pos    newest_zero;
        logic    last_dev;
        logic    active;
        t_result search_results_due[$];
        int      errors;

        function new();
            clear_search();
            errors = 0;
        endfunction

        function void drop_search();
            last_disc = '0;
            fam_disc  = '0;
            last_dev  = 1'b0;
        endfunction

        function void clear_search();
            rom         = '0;
            bit_pos     = '0;
            newest_zero = '0;
            active      = 1'b0;
            drop_search();
        endfunction

        function t_result note_request(t_item req);
            t_result res;
            t_pos    n;
            logic [5:0] idx;
            res.status    = ST_IGNORED;
            res.direction = 1'b0;
            if (req.kind == KIND_CLEAR) begin
                clear_search();
                res.status = ST_STARTED;
            end else if (req.kind == KIND_BEGIN) begin
                active      = 1'b0;
                bit_pos     = '0;
                newest_zero = '0;
                if (last_dev || !req.presence) begin
                    drop_search();
                    res.status = ST_FAIL;
                end else begin
                    active     = 1'b1;
                    res.status = ST_STARTED;
                end
            end else if (req.kind == KIND_PAIR && active) begin
                if (req.id_bit && req.complement_bit) begin
                    drop_search();
                    active     = 1'b0;
                    res.status = ST_FAIL;
                end else begin
                    idx = bit_pos[5:0];
                    n   = t_pos'(bit_pos + 1);
                    if (req.id_bit != req.complement_bit) begin
                        res.direction = req.id_bit;
                    end else begin
                        // devices answer with both values: follow the last discrepancy rule
                        if (n < last_disc) begin
                            res.direction = rom[idx];
                        end else begin
                            res.direction = (n == last_disc);
                        end
                        if (!res.direction) begin
                            newest_zero = n;
                            if (n < FAMILY_LIMIT) begin
                                fam_disc = n;
                            end
                        end
                    end
                    rom[idx]   = res.direction;
                    bit_pos    = n;
                    res.status = ST_SEND;
                    if (n >= TOTAL_POS) begin
                        active    = 1'b0;
                        last_disc = newest_zero;
                        if (last_disc == 0) begin
                            last_dev = 1'b1;
                        end
                        if (rom[7:0] == 8'h00) begin
                            drop_search();
                            res.status = ST_FAIL;
                        end else begin
                            res.status = ST_FOUND;
                        end
                    end
                end
            end
            res.rom_id             = rom;
            res.family_discrepancy = fam_disc;
            res.last_device        = last_dev;
            search_results_due.push_back(res);
            return res;
        endfunction

        function void field_diff(string name, t_rom want, t_rom got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (search_results_due.size() == 0) begin
                $display("%0t: result with no request pending, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            want = search_results_due.pop_front();
            field_diff("status", t_rom'(want.status), t_rom'(got.status));
            field_diff("direction", t_rom'(want.direction), t_rom'(got.direction));
            field_diff("rom_id", want.rom_id, got.rom_id);
            field_diff("family_discrepancy", t_rom'(want.family_discrepancy),
                       t_rom'(got.family_discrepancy));
            field_diff("last_device", t_rom'(want.last_device), t_rom'(got.last_device));
        endfunction

        function int outstanding();
            return search_results_due.size();
        endfunction

        function bit pass_open();
            return active;
        endfunction

        function t_pos bits_done();
            return bit_pos;
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind           = 2'd0;
    logic        i_presence       = 1'b0;
    logic        i_id_bit         = 1'b0;
    logic        i_complement_bit = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [2:0]  o_status;
    logic        o_direction;
    logic [63:0] o_rom_id;
    logic [6:0]  o_family_discrepancy;
    logic        o_last_device;

    search_scoreboard sb = new();
    t_idle_mode idle_mode  = IDLE_NONE;
    bit         hold_req   = 1'b0;
    int         items_done = 0;
    t_rom       devices [MAX_DEVICES];
    logic [MAX_DEVICES-1:0] alive;

    onewire_rom_search_unit u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_kind               (i_kind),
        .i_presence           (i_presence),
        .i_id_bit             (i_id_bit),
        .i_complement_bit     (i_complement_bit),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_direction          (o_direction),
        .o_rom_id             (o_rom_id),
        .o_family_discrepancy (o_family_discrepancy),
        .o_last_device        (o_last_device)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side: check every accepted result, stall at random or for a long hold-off
    initial begin
        int hold_left;
        int pct;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_result('{o_status, o_direction, o_rom_id,
                                  o_family_discrepancy, o_last_device});
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            pct = (idle_mode == IDLE_RECEIVER) ? 70 : (idle_mode == IDLE_BOTH) ? 14 : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (pct != 0) && ($urandom_range(99) < pct);
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // offer one request, wait for it to be taken, return what it should produce
    task automatic send_item(input t_kind kind, input logic presence, input logic id_bit,
                             input logic complement_bit, output t_result want);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 70 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        while (pct != 0 && $urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_kind           <= kind;
        i_presence       <= presence;
        i_id_bit         <= id_bit;
        i_complement_bit <= complement_bit;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        want = sb.note_request('{kind, presence, id_bit, complement_bit});
        if (want.status != ST_IGNORED) begin
            items_done++;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // one bus population enumerated pass by pass, the bus answering as a wired-and
    task automatic run_population();
        int      ndev;
        int      passes;
        int      roll;
        t_rom    base;
        t_result got;
        t_pos    n;
        t_kind   kind;
        logic    idb;
        logic    cmp;
        logic    pres;
        ndev = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        base = {$urandom, $urandom};
        if (base[7:0] == 8'h00) begin
            base[0] = 1'b1;
        end
        for (int d = 0; d < MAX_DEVICES; d++) begin
            // sparse flips keep long shared prefixes between devices
            devices[d] = base ^ ({$urandom, $urandom} & {$urandom, $urandom}
                                 & {$urandom, $urandom});
        end
        if ($urandom_range(2) == 0) begin
            devices[0][7:0] = 8'h00;
        end
        send_item(KIND_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), got);
        passes = 0;
        while (passes < ndev + 3) begin
            passes++;
            pres = (ndev != 0) && ($urandom_range(19) != 0);
            send_item(KIND_BEGIN, pres, 1'($urandom_range(1)), 1'($urandom_range(1)), got);
            if (!sb.pass_open()) begin
                break;
            end
            while (sb.pass_open()) begin
                n = sb.bits_done();
                if (n == 0) begin
                    alive = MAX_DEVICES'((1 << ndev) - 1);
                end
                idb = 1'b1;
                cmp = 1'b1;
                for (int d = 0; d < ndev; d++) begin
                    if (alive[d]) begin
                        idb &= devices[d][n[5:0]];
                        cmp &= ~devices[d][n[5:0]];
                    end
                end
                kind = KIND_PAIR;
                roll = $urandom_range(99);
                if (roll == 0) begin
                    kind = t_kind'($urandom_range(3));
                    idb  = 1'($urandom_range(1));
                    cmp  = 1'($urandom_range(1));
                end else if (roll == 1) begin
                    // corrupted read on the bus
                    if ($urandom_range(1)) begin
                        idb = ~idb;
                    end else begin
                        cmp = ~cmp;
                    end
                end
                send_item(kind, 1'($urandom_range(1)), idb, cmp, got);
                if (kind == KIND_PAIR) begin
                    for (int d = 0; d < ndev; d++) begin
                        if (devices[d][n[5:0]] != got.direction) begin
                            alive[d] = 1'b0;
                        end
                    end
                end
            end
        end
    endtask

    initial begin
        t_result got;
        int      target;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_mode = IDLE_BOTH;
        send_item(KIND_CLEAR, 1'b0, 1'b0, 1'b0, got);
        send_item(KIND_PAIR, 1'b0, 1'b1, 1'b0, got);     // no pass open
        send_item(KIND_SPARE, 1'b1, 1'b1, 1'b1, got);
        send_item(KIND_BEGIN, 1'b0, 1'b0, 1'b0, got);    // nobody answered
        send_item(KIND_BEGIN, 1'b1, 1'b0, 1'b0, got);
        send_item(KIND_PAIR, 1'b0, 1'b0, 1'b1, got);
        send_item(KIND_PAIR, 1'b1, 1'b1, 1'b0, got);
        send_item(KIND_PAIR, 1'b0, 1'b0, 1'b0, got);     // discrepancy in family byte
        send_item(KIND_BEGIN, 1'b1, 1'b1, 1'b1, got);    // restart mid-pass
        send_item(KIND_PAIR, 1'b0, 1'b1, 1'b0, got);
        send_item(KIND_PAIR, 1'b1, 1'b1, 1'b1, got);     // no device on the bus
        send_item(KIND_PAIR, 1'b0, 1'b0, 1'b0, got);
        send_item(KIND_SPARE, 1'b0, 1'b0, 1'b0, got);
        send_item(KIND_BEGIN, 1'b1, 1'b0, 1'b0, got);
        send_item(KIND_PAIR, 1'b1, 1'b0, 1'b0, got);
        send_item(KIND_CLEAR, 1'b1, 1'b1, 1'b1, got);    // clear mid-pass
        send_item(KIND_PAIR, 1'b1, 1'b1, 1'b0, got);
        drain();

        target = items_done;
        for (int p = 0; p < 4; p++) begin
            idle_mode = t_idle_mode'(p);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            target += PHASE_ITEMS;
            while (items_done < target) begin
                run_population();
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ors_pkg.sv
design/ors_in_stage.sv
design/ors_decide.sv
design/ors_out_stage.sv
design/onewire_rom_search_unit.sv
bench/tb_top.sv
